[rtl/cirp_pkg.sv]
// Shared constants, register map, kind codes and control structs of the
// integrate-and-reset pixel block. No dependencies.
`default_nettype none

package cirp_pkg;

   // Store geometry
   localparam int MAX_ELECTRONS = 1024;
   localparam int ADDR_W        = $clog2(MAX_ELECTRONS);
   localparam int CNT_W         = ADDR_W + 1;

   // Field widths
   localparam int NOISE_FRAC_BITS = 8;
   localparam int KIND_W   = 2;
   localparam int TIME_W   = 31;
   localparam int PTIME_W  = TIME_W + 1;
   localparam int NOISE_W  = 16;
   localparam int CHARGE_W = 17;
   localparam int CFG16_W  = 16;

   // Input kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEW    = 2'd2;

   // Register map
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;
   localparam int REGIDX_W = 3;
   localparam logic [REGIDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
   localparam logic [REGIDX_W-1:0] REG_STOP_TIME     = 3'd1;
   localparam logic [REGIDX_W-1:0] REG_THRESHOLD     = 3'd2;
   localparam logic [REGIDX_W-1:0] REG_DEAD_PERIOD   = 3'd3;
   localparam logic [REGIDX_W-1:0] REG_LOSS_ENABLE   = 3'd4;

   // Register reset values
   localparam logic [CFG16_W-1:0] RST_SAMPLE_PERIOD = 16'd10;
   localparam logic [TIME_W-1:0]  RST_STOP_TIME     = 31'd1000;
   localparam logic [CFG16_W-1:0] RST_THRESHOLD     = 16'd6250;
   localparam logic [CFG16_W-1:0] RST_DEAD_PERIOD   = 16'd0;
   localparam logic               RST_LOSS_ENABLE   = 1'b0;

   typedef struct packed {
      logic [CFG16_W-1:0] sample_period;
      logic [TIME_W-1:0]  stop_time;
      logic [CFG16_W-1:0] reset_threshold;
      logic [CFG16_W-1:0] dead_period;
      logic               charge_loss_enable;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic item_start;
      logic append;
      logic new_pixel;
      logic step;
      logic count_inc;
      logic fire;
      logic loss_inc;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic live;
      logic more;
      logic earlier;
      logic fire_cond;
      logic loss_en;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/cirp_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on cirp_pkg for field widths.
`default_nettype none

interface cirp_req_if import cirp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TIME_W-1:0]   arrival_time;
   logic signed [NOISE_W-1:0] noise;

   modport source (output valid, kind, arrival_time, noise, input ready);
   modport sink   (input valid, kind, arrival_time, noise, output ready);
endinterface

interface cirp_rsp_if import cirp_pkg::*;;
   logic                valid;
   logic                ready;
   logic                reset_fired;
   logic [TIME_W-1:0]   reset_time;
   logic                finished;
   logic signed [CHARGE_W-1:0] charge_now;
   logic                store_full;

   modport source (output valid, reset_fired, reset_time, finished, charge_now,
                   store_full, input ready);
   modport sink   (input valid, reset_fired, reset_time, finished, charge_now,
                   store_full, output ready);
endinterface

`default_nettype wire

[rtl/cirp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cirp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[rtl/cirp_csr.sv]
// APB-style configuration registers of the pixel block.
// Depends on cirp_pkg for the register map and reset values.
`default_nettype none

module cirp_csr import cirp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type              cfg_ff, cfg_in;
   logic [REGIDX_W-1:0]  idx;
   logic                 wr;

   assign pready = 1'b1;
   assign idx    = paddr[PADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_SAMPLE_PERIOD: cfg_in.sample_period      = pwdata[CFG16_W-1:0];
            REG_STOP_TIME:     cfg_in.stop_time          = pwdata[TIME_W-1:0];
            REG_THRESHOLD:     cfg_in.reset_threshold    = pwdata[CFG16_W-1:0];
            REG_DEAD_PERIOD:   cfg_in.dead_period        = pwdata[CFG16_W-1:0];
            REG_LOSS_ENABLE:   cfg_in.charge_loss_enable = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period      <= RST_SAMPLE_PERIOD;
         cfg_ff.stop_time          <= RST_STOP_TIME;
         cfg_ff.reset_threshold    <= RST_THRESHOLD;
         cfg_ff.dead_period        <= RST_DEAD_PERIOD;
         cfg_ff.charge_loss_enable <= RST_LOSS_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_SAMPLE_PERIOD: prdata = PDATA_W'(cfg_ff.sample_period);
         REG_STOP_TIME:     prdata = PDATA_W'(cfg_ff.stop_time);
         REG_THRESHOLD:     prdata = PDATA_W'(cfg_ff.reset_threshold);
         REG_DEAD_PERIOD:   prdata = PDATA_W'(cfg_ff.dead_period);
         REG_LOSS_ENABLE:   prdata = PDATA_W'(cfg_ff.charge_loss_enable);
         default:           prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/cirp_ctrl.sv]
// Control state machine: sequences appends, sample steps, the electron
// walk and the dead-time skip. Depends on cirp_pkg for kinds and structs.
`default_nettype none

module cirp_ctrl import cirp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_ready,
   input  wire status_type        status,
   output cmd_type                cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_COUNT_RD  = 3'd1;
   localparam logic [2:0] ST_COUNT_CMP = 3'd2;
   localparam logic [2:0] ST_CHECK     = 3'd3;
   localparam logic [2:0] ST_LOSS_RD   = 3'd4;
   localparam logic [2:0] ST_LOSS_CMP  = 3'd5;
   localparam logic [2:0] ST_OUT       = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.item_start = 1'b1;
               state_in       = ST_OUT;
               unique case (req_kind)
                  KIND_APPEND: cmd.append    = 1'b1;
                  KIND_NEW:    cmd.new_pixel = 1'b1;
                  KIND_STEP: begin
                     if (status.live) begin
                        cmd.step = 1'b1;
                        state_in = ST_COUNT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // RAM address is the walk pointer; data lands in the next cycle
         ST_COUNT_RD: begin
            state_in = status.more ? ST_COUNT_CMP : ST_CHECK;
         end
         ST_COUNT_CMP: begin
            if (status.earlier) begin
               cmd.count_inc = 1'b1;
               state_in      = ST_COUNT_RD;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.fire_cond) begin
               cmd.fire = 1'b1;
               state_in = status.loss_en ? ST_LOSS_RD : ST_OUT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LOSS_RD: begin
            state_in = status.more ? ST_LOSS_CMP : ST_OUT;
         end
         ST_LOSS_CMP: begin
            if (status.earlier) begin
               cmd.loss_inc = 1'b1;
               state_in     = ST_LOSS_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cirp_dpath.sv]
// Datapath: pixel clock, charge, store pointers, electron store and the
// response register. Depends on cirp_pkg and cirp_ram.
`default_nettype none

module cirp_dpath import cirp_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire cfg_type                    cfg,
   input  wire logic [TIME_W-1:0]          req_arrival_time,
   input  wire logic signed [NOISE_W-1:0]  req_noise,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_reset_fired,
   output logic [TIME_W-1:0]               rsp_reset_time,
   output logic                            rsp_finished,
   output logic signed [CHARGE_W-1:0]      rsp_charge_now,
   output logic                            rsp_store_full
);

   localparam int SUM_W   = CHARGE_W + 1 + NOISE_FRAC_BITS;
   localparam int WHOLE_W = CHARGE_W + 1;
   localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << NOISE_FRAC_BITS) - 1);
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_ELECTRONS);
   localparam logic signed [CHARGE_W-1:0] CHARGE_TOP = {1'b0, {(CHARGE_W-1){1'b1}}};

   logic [PTIME_W-1:0]         pixel_time_ff, pixel_time_in;
   logic signed [CHARGE_W-1:0] charge_ff, charge_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           next_ff, next_in;
   logic                       fired_ff, fired_in;
   logic [TIME_W-1:0]          rtime_ff, rtime_in;
   logic                       full_ff, full_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_fired_ff;
   logic [TIME_W-1:0]          rsp_rtime_ff;
   logic                       rsp_finished_ff;
   logic signed [CHARGE_W-1:0] rsp_charge_ff;
   logic                       rsp_full_ff;

   logic                       store_has_room;
   logic                       ram_we;
   logic [TIME_W-1:0]          ram_rdata;
   logic signed [SUM_W-1:0]    sum;
   logic signed [SUM_W-1:0]    sum_rnd;
   logic signed [WHOLE_W-1:0]  whole;
   logic signed [CHARGE_W-1:0] charge_step;
   logic [TIME_W-1:0]          time_sat;
   logic                       finished_now;

   assign store_has_room = (count_ff != COUNT_FULL);
   assign ram_we         = cmd.append && store_has_room;

   // electron arrival store, read at the walk pointer
   cirp_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_ELECTRONS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (req_arrival_time),
      .raddr (next_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // noise add with truncation toward zero, then saturate to charge range
   assign sum     = (SUM_W'(charge_ff) <<< NOISE_FRAC_BITS) + SUM_W'(req_noise);
   assign sum_rnd = sum + (sum[SUM_W-1] ? FRAC_MASK : '0);
   assign whole   = sum_rnd[SUM_W-1:NOISE_FRAC_BITS];
   always_comb begin
      if (whole[WHOLE_W-1] != whole[WHOLE_W-2]) begin
         charge_step = whole[WHOLE_W-1] ? {1'b1, {(CHARGE_W-1){1'b0}}} : CHARGE_TOP;
      end else begin
         charge_step = whole[CHARGE_W-1:0];
      end
   end

   assign time_sat     = pixel_time_ff[PTIME_W-1] ? {TIME_W{1'b1}} : pixel_time_ff[TIME_W-1:0];
   assign finished_now = (pixel_time_ff > {1'b0, cfg.stop_time});

   // status to controller
   always_comb begin
      status.live      = !finished_now;
      status.more      = (next_ff < count_ff);
      status.earlier   = ({1'b0, ram_rdata} < pixel_time_ff);
      status.fire_cond = ($signed({charge_ff[CHARGE_W-1], charge_ff}) >=
                          $signed({2'b00, cfg.reset_threshold}));
      status.loss_en   = cfg.charge_loss_enable;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // state update
   always_comb begin
      pixel_time_in = pixel_time_ff;
      charge_in     = charge_ff;
      count_in      = count_ff;
      next_in       = next_ff;
      fired_in      = fired_ff;
      rtime_in      = rtime_ff;
      full_in       = full_ff;
      if (cmd.item_start) begin
         fired_in = 1'b0;
         rtime_in = '0;
         full_in  = 1'b0;
      end
      if (cmd.new_pixel) begin
         pixel_time_in = '0;
         charge_in     = '0;
         count_in      = '0;
         next_in       = '0;
      end
      if (cmd.append) begin
         if (store_has_room) begin
            count_in = count_ff + 1'b1;
         end else begin
            full_in = 1'b1;
         end
      end
      if (cmd.step) begin
         pixel_time_in = pixel_time_ff + PTIME_W'(cfg.sample_period);
         charge_in     = charge_step;
      end
      if (cmd.count_inc) begin
         next_in = next_ff + 1'b1;
         if (charge_ff != CHARGE_TOP) begin
            charge_in = charge_ff + CHARGE_W'(1);
         end
      end
      if (cmd.loss_inc) begin
         next_in = next_ff + 1'b1;
      end
      if (cmd.fire) begin
         fired_in      = 1'b1;
         rtime_in      = time_sat;
         charge_in     = '0;
         pixel_time_in = pixel_time_ff + PTIME_W'(cfg.dead_period);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_time_ff <= '0;
         charge_ff     <= '0;
         count_ff      <= '0;
         next_ff       <= '0;
         fired_ff      <= 1'b0;
         rtime_ff      <= '0;
         full_ff       <= 1'b0;
      end else begin
         pixel_time_ff <= pixel_time_in;
         charge_ff     <= charge_in;
         count_ff      <= count_in;
         next_ff       <= next_in;
         fired_ff      <= fired_in;
         rtime_ff      <= rtime_in;
         full_ff       <= full_in;
      end
   end

   // response register
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_fired_ff    <= fired_ff;
         rsp_rtime_ff    <= rtime_ff;
         rsp_finished_ff <= finished_now;
         rsp_charge_ff   <= charge_ff;
         rsp_full_ff     <= full_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reset_fired = rsp_fired_ff;
   assign rsp_reset_time  = rsp_rtime_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_charge_now  = rsp_charge_ff;
   assign rsp_store_full  = rsp_full_ff;

endmodule

`default_nettype wire

[rtl/charge_integrate_and_reset_pixel.sv]
// Integrate-and-reset pixel front end: request/response channels and an
// APB-style register port. Depends on cirp_pkg, cirp_if, cirp_csr,
// cirp_ctrl, cirp_dpath and cirp_ram.
//
// req_if carries one item per transfer: kind 0 appends an electron arrival
//   time to a 1024-entry store, kind 1 runs one sample step, kind 2 starts a
//   new pixel, kind 3 only reports the current state. rsp_if returns exactly
//   one result per item, in order. Registers are to be written only while
//   idle; the block itself does not enforce this. Items are handled one
//   at a time. An append, a new pixel, kind 3 or a step past the end time
//   goes from idle to ST_OUT, which loads the output register. A sample
//   step walks the store in ST_COUNT_RD and ST_COUNT_CMP, adding a charge
//   per stored time before the pixel time up to the first later one, then
//   ST_CHECK; a reset with charge loss on skips stored times before the new
//   pixel time in ST_LOSS_RD and ST_LOSS_CMP, then ST_OUT. Each stored time
//   costs a read and a compare state on the single registered read port.
// Reset: synchronous; clears the pixel clock, charge, store pointers and
//   loads the register defaults. The store contents are not cleared.
// Stall: a result waits in the output register while rsp_if.ready is low;
//   the next item is still taken and held until the register frees.
`default_nettype none

module charge_integrate_and_reset_pixel import cirp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   cirp_req_if.sink                req_if,
   cirp_rsp_if.source              rsp_if,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   cirp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   cirp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // pixel state, store and response register
   cirp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_arrival_time (req_if.arrival_time),
      .req_noise        (req_if.noise),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_reset_fired  (rsp_if.reset_fired),
      .rsp_reset_time   (rsp_if.reset_time),
      .rsp_finished     (rsp_if.finished),
      .rsp_charge_now   (rsp_if.charge_now),
      .rsp_store_full   (rsp_if.store_full)
   );

endmodule

`default_nettype wire
